@@ sv/apq_pkg.sv @@
// Shared types and constants for the aging priority task queue.
// No dependencies; every other file of the block imports this package.
package apq_pkg;

   localparam int PRIO_BITS = 2;
   localparam int AGE_GROUP = 3;

   localparam logic [PRIO_BITS-1:0] PRIO_BEST = 2'd1;
   localparam logic [PRIO_BITS-1:0] PRIO_NONE = 2'd0;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_AGE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Completion handshake from the sequencer to the output register.
   typedef struct packed {
      logic       done;
      status_type status;
   } apq_res_type;

endpackage

@@ sv/apq_table.sv @@
// Task table storage: tag and priority memories, one write port and one
// registered read port. Depends on apq_pkg.
module apq_table import apq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 16,
   localparam int IdxBits    = $clog2(QUEUE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IdxBits-1:0]   wr_addr,
   input  logic [TAG_BITS-1:0]  wr_tag,
   input  logic [PRIO_BITS-1:0] wr_prio,
   input  logic                 rd_en,
   input  logic [IdxBits-1:0]   rd_addr,
   output logic [TAG_BITS-1:0]  rd_tag,
   output logic [PRIO_BITS-1:0] rd_prio
);

   logic [TAG_BITS-1:0]  tag_mem_ff  [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0] prio_mem_ff [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  rd_tag_ff;
   logic [PRIO_BITS-1:0] rd_prio_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[wr_addr]  <= wr_tag;
         prio_mem_ff[wr_addr] <= wr_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff  <= tag_mem_ff[rd_addr];
         rd_prio_ff <= prio_mem_ff[rd_addr];
      end
   end

   assign rd_tag  = rd_tag_ff;
   assign rd_prio = rd_prio_ff;

endmodule

@@ sv/apq_ctrl.sv @@
// Action sequencer: walks the task table one entry per cycle for search,
// compaction and aging, with one shared compare unit. Depends on apq_pkg
// and apq_table.
module apq_ctrl import apq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 16,
   localparam int IdxBits    = $clog2(QUEUE_DEPTH),
   localparam int CountBits  = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_take,
   output logic                 idle,
   input  action_type           req_action,
   input  logic [PRIO_BITS-1:0] req_new_priority,
   input  logic [TAG_BITS-1:0]  req_target_tag,
   input  logic [PRIO_BITS-1:0] req_wanted_priority,
   output apq_res_type          res,
   input  logic                 res_take,
   output logic [TAG_BITS-1:0]  res_tag,
   output logic [PRIO_BITS-1:0] res_prio,
   output logic [CountBits-1:0] res_count
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_SHIFT  = 5'b00100,
      S_AGE    = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   localparam int ThrBits = CountBits + 2;
   localparam logic [ThrBits-1:0]   AgeStep   = ThrBits'(AGE_GROUP);
   localparam logic [CountBits-1:0] FullCount = CountBits'(QUEUE_DEPTH);
   localparam logic [CountBits-1:0] CountOne  = CountBits'(1);

   state_type            state_ff, state_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [TAG_BITS-1:0]  next_tag_ff, next_tag_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [CountBits-1:0] ptr_ff, ptr_in;
   logic [ThrBits-1:0]   thr_ff, thr_in;
   logic [IdxBits-1:0]   rd_idx_ff, rd_idx_in;
   action_type           act_ff, act_in;
   logic [TAG_BITS-1:0]  target_ff, target_in;
   logic [PRIO_BITS-1:0] wanted_ff, wanted_in;
   status_type           status_ff, status_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;

   logic                 wr_en, rd_en;
   logic [IdxBits-1:0]   wr_addr, rd_addr;
   logic [TAG_BITS-1:0]  wr_tag, rd_tag;
   logic [PRIO_BITS-1:0] wr_prio, rd_prio;

   logic                 issue;
   logic                 key_hit;
   logic                 at_last;
   logic [PRIO_BITS-1:0] push_prio;

   apq_table #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_tag  (wr_tag),
      .wr_prio (wr_prio),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_tag  (rd_tag),
      .rd_prio (rd_prio)
   );

   // The shared compare unit: tag match for remove, priority match for find.
   assign key_hit = rd_valid_ff && ((act_ff == ACT_REMOVE) ? (rd_tag == target_ff)
                                                           : (rd_prio == wanted_ff));
   assign at_last   = (CountBits'(rd_idx_ff) == (count_ff - CountOne));
   assign push_prio = (req_new_priority == PRIO_NONE) ? PRIO_BEST : req_new_priority;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      next_tag_in = next_tag_ff;
      rd_valid_in = 1'b0;
      ptr_in      = ptr_ff;
      thr_in      = thr_ff;
      rd_idx_in   = rd_idx_ff;
      act_in      = act_ff;
      target_in   = target_ff;
      wanted_in   = wanted_ff;
      status_in   = status_ff;
      tag_in      = tag_ff;
      prio_in     = prio_ff;
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_tag      = rd_tag;
      wr_prio     = rd_prio;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[IdxBits-1:0];
      issue       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in    = req_action;
               target_in = req_target_tag;
               wanted_in = req_wanted_priority;
               status_in = ST_OK;
               tag_in    = '0;
               prio_in   = PRIO_NONE;
               ptr_in    = '0;
               thr_in    = AgeStep;
               state_in  = S_FINISH;
               case (req_action)
                  ACT_PUSH: begin
                     if (count_ff == FullCount) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = count_ff[IdxBits-1:0];
                        wr_tag      = next_tag_ff;
                        wr_prio     = push_prio;
                        count_in    = count_ff + CountOne;
                        next_tag_in = next_tag_ff + TAG_BITS'(1);
                        tag_in      = next_tag_ff;
                        prio_in     = push_prio;
                     end
                  end
                  ACT_REMOVE, ACT_FIND: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_AGE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            issue       = (ptr_ff < count_ff);
            rd_en       = issue;
            rd_valid_in = issue;
            rd_idx_in   = ptr_ff[IdxBits-1:0];
            if (issue) begin
               ptr_in = ptr_ff + CountOne;
            end
            if (key_hit) begin
               rd_valid_in = 1'b0;
               if (act_ff == ACT_REMOVE) begin
                  if (at_last) begin
                     count_in = count_ff - CountOne;
                     state_in = S_FINISH;
                  end else begin
                     ptr_in   = CountBits'(rd_idx_ff) + CountOne;
                     state_in = S_SHIFT;
                  end
               end else begin
                  tag_in   = rd_tag;
                  prio_in  = rd_prio;
                  state_in = S_FINISH;
               end
            end else if (rd_valid_ff && at_last) begin
               rd_valid_in = 1'b0;
               status_in   = ST_MISS;
               state_in    = S_FINISH;
            end
         end

         S_SHIFT: begin
            // Entry k+1 is read while entry k-1 takes the word read before.
            issue       = (ptr_ff < count_ff);
            rd_en       = issue;
            rd_valid_in = issue;
            rd_idx_in   = ptr_ff[IdxBits-1:0];
            if (issue) begin
               ptr_in = ptr_ff + CountOne;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IdxBits'(1);
               if (at_last) begin
                  rd_valid_in = 1'b0;
                  count_in    = count_ff - CountOne;
                  state_in    = S_FINISH;
               end
            end
         end

         S_AGE: begin
            // Entry i is aged while 3*(i+1) does not exceed the count.
            issue       = (thr_ff <= ThrBits'(count_ff));
            rd_en       = issue;
            rd_valid_in = issue;
            rd_idx_in   = ptr_ff[IdxBits-1:0];
            if (issue) begin
               ptr_in = ptr_ff + CountOne;
               thr_in = thr_ff + AgeStep;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff;
               wr_prio = (rd_prio > PRIO_BEST) ? (rd_prio - PRIO_BEST) : rd_prio;
            end else if (!issue) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         next_tag_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         next_tag_ff <= next_tag_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      thr_ff    <= thr_in;
      rd_idx_ff <= rd_idx_in;
      act_ff    <= act_in;
      target_ff <= target_in;
      wanted_ff <= wanted_in;
      status_ff <= status_in;
      tag_ff    <= tag_in;
      prio_ff   <= prio_in;
   end

   assign idle       = (state_ff == S_IDLE);
   assign res.done   = (state_ff == S_FINISH);
   assign res.status = status_ff;
   assign res_tag    = tag_ff;
   assign res_prio   = prio_ff;
   assign res_count  = count_ff;

endmodule

@@ sv/aging_priority_task_queue_core.sv @@
// Top level of the aging priority task queue: request handshake, sequencer
// and the registered response word. Depends on apq_pkg and apq_ctrl.
//
// The block holds up to QUEUE_DEPTH tasks in arrival order, each with a
// TAG_BITS sequence tag and a priority from 1 (best) to 3, in a table memory
// with one write port and one registered read port. A request word carries
// one action: push appends a task under the next tag (priority 0 is taken as
// 1), remove deletes the oldest task with the given tag and closes the gap,
// find reports the oldest task with the wanted priority, and age lowers by
// one the priority of the first floor(count/3) tasks, never below 1. Every
// request returns exactly one response word with a status, the found or
// pushed task (zero otherwise) and the count held afterwards. The sequencer
// handles one request at a time and walks the table one entry per clock
// through one compare unit. A push, a push to a full table, and a remove or
// a find on an empty table go from idle straight to the finish state. The
// scan reads one entry per cycle and checks it the next; a find or a remove
// that checks the last entry without a hit reports a miss. A remove that hits
// the last entry ends there, and one that hits at an earlier entry h is
// followed by the move, which reads again from entry h+1 and writes each
// later entry down one place. Age writes no entry when the count is below 3.
// A new request is taken as soon as the sequencer is idle, even while the
// previous response word still waits on rsp_ready; the response register
// then holds that word and the sequencer waits at its end until the register
// frees up.
module aging_priority_task_queue_core import apq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [PRIO_BITS-1:0]                  req_new_priority,
   input  logic [TAG_BITS-1:0]                   req_target_tag,
   input  logic [PRIO_BITS-1:0]                  req_wanted_priority,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [TAG_BITS-1:0]                   rsp_found_tag,
   output logic [PRIO_BITS-1:0]                  rsp_found_priority,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]    rsp_task_count
);

   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   logic                 ctrl_idle;
   logic                 req_take;
   logic                 out_load;
   apq_res_type          ctrl_res;
   logic [TAG_BITS-1:0]  ctrl_tag;
   logic [PRIO_BITS-1:0] ctrl_prio;
   logic [CountBits-1:0] ctrl_count;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [PRIO_BITS-1:0] rsp_prio_ff;
   logic [CountBits-1:0] rsp_count_ff;

   // A request word is taken whenever the sequencer has nothing in flight.
   assign req_ready = ctrl_idle;
   assign req_take  = req_valid && ctrl_idle;

   apq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_take            (req_take),
      .idle                (ctrl_idle),
      .req_action          (action_type'(req_action)),
      .req_new_priority    (req_new_priority),
      .req_target_tag      (req_target_tag),
      .req_wanted_priority (req_wanted_priority),
      .res                 (ctrl_res),
      .res_take            (out_load),
      .res_tag             (ctrl_tag),
      .res_prio            (ctrl_prio),
      .res_count           (ctrl_count)
   );

   // The response register loads when it is empty or its word leaves now.
   assign out_load = ctrl_res.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= ctrl_res.status;
         rsp_tag_ff    <= ctrl_tag;
         rsp_prio_ff   <= ctrl_prio;
         rsp_count_ff  <= ctrl_count;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_tag      = rsp_tag_ff;
   assign rsp_found_priority = rsp_prio_ff;
   assign rsp_task_count     = rsp_count_ff;

endmodule
